/* hw/rtl/mmex_pkg.sv */
// Package for the multiset mex tracker.
// Holds field widths, command codes and the bitmap word layout.
// No dependencies.
package mmex_pkg;

    localparam int VALUE_W    = 10;
    localparam int RESULT_W   = 11;
    localparam int WORD_BITS  = 32;
    localparam int WORD_SHIFT = 5;

    typedef logic [1:0]            cmd_t;
    typedef logic [VALUE_W-1:0]    value_t;
    typedef logic [RESULT_W-1:0]   result_t;
    typedef logic [WORD_BITS-1:0]  word_t;
    typedef logic [WORD_SHIFT-1:0] bit_pos_t;

    localparam cmd_t CMD_ADD    = 2'd0;
    localparam cmd_t CMD_REMOVE = 2'd1;
    localparam cmd_t CMD_QUERY  = 2'd2;

    typedef struct packed {
        logic     found;
        bit_pos_t pos;
    } ffz_res_t;

endpackage

/* hw/rtl/mmex_ffz.sv */
// Find-first-zero unit over one presence bitmap word.
// Halving search, one level per position bit.
// Depends on mmex_pkg.
module mmex_ffz
(
    input  mmex_pkg::word_t    word,
    output mmex_pkg::ffz_res_t res
);

    always_comb
    begin
        mmex_pkg::word_t    w;
        mmex_pkg::word_t    mask;
        mmex_pkg::bit_pos_t pos;
        w   = word;
        pos = '0;
        for (int lvl = mmex_pkg::WORD_SHIFT - 1; lvl >= 0; lvl--)
        begin
            mask = (mmex_pkg::word_t'(1) << (1 << lvl)) - mmex_pkg::word_t'(1);
            if (((~w) & mask) == '0)
            begin
                w        = w >> (1 << lvl);
                pos[lvl] = 1'b1;
            end
        end
        res.found = (~word) != '0;
        res.pos   = pos;
    end

endmodule

/* hw/rtl/multiset_mex_tracker_unit.sv */
// Top level of the multiset mex tracker: count memory, bitmap memory, sequencer.
// Depends on mmex_pkg and mmex_ffz.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------
//  in      | request   | in_valid / in_stall  | command, value
//  out     | result    | out_valid / out_stall| smallest_missing
//
// Add or remove: count and bitmap read, then read-modify-write.
// Query: scans k bitmap words, k at most ceil(NUM_VALUES/32);
// the single find-first-zero unit examines one 32-bit word per cycle.
// Reset: both memories are swept to zero while in_stall is high.
// A result waits in the output register; a query that finishes while it is
// still stalled holds until the register frees.
module multiset_mex_tracker_unit
#(
    parameter int NUM_VALUES = 1024,
    parameter int COUNT_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  mmex_pkg::cmd_t        command,
    input  mmex_pkg::value_t      value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output mmex_pkg::result_t     smallest_missing
);

    localparam int CNT_AW  = $clog2(NUM_VALUES);
    localparam int WORDS   = (NUM_VALUES + mmex_pkg::WORD_BITS - 1) / mmex_pkg::WORD_BITS;
    localparam int WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int EXT_W   = (CNT_AW + 1 > mmex_pkg::VALUE_W) ? CNT_AW + 1 : mmex_pkg::VALUE_W;
    localparam int RES_A   = (WORD_AW + mmex_pkg::WORD_SHIFT + 1 > CNT_AW + 1)
                             ? WORD_AW + mmex_pkg::WORD_SHIFT + 1 : CNT_AW + 1;
    localparam int RES_W   = (RES_A > mmex_pkg::RESULT_W) ? RES_A : mmex_pkg::RESULT_W;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_UPDATE = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [2:0]            state_reg, state_next;
    logic [CNT_AW-1:0]     clr_reg, clr_next;
    mmex_pkg::cmd_t        cmd_reg, cmd_next;
    logic [EXT_W-1:0]      val_reg, val_next;
    logic [WORD_AW-1:0]    scan_reg, scan_next;
    logic [RES_W-1:0]      res_reg, res_next;
    logic                  out_valid_reg, out_valid_next;
    mmex_pkg::result_t     out_data_reg, out_data_next;

    logic [COUNT_BITS-1:0] count_mem [NUM_VALUES];
    mmex_pkg::word_t       word_mem  [WORDS];
    logic [COUNT_BITS-1:0] cnt_rdata_reg;
    mmex_pkg::word_t       word_rdata_reg;

    logic                  cnt_we;
    logic [CNT_AW-1:0]     cnt_waddr, cnt_raddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic                  word_we;
    logic [WORD_AW-1:0]    word_waddr, word_raddr;
    mmex_pkg::word_t       word_wdata;

    logic [EXT_W-1:0]      value_ext;
    logic                  in_range;
    logic                  accept;
    logic                  scan_last;
    logic [RES_W-1:0]      found_idx;
    mmex_pkg::word_t       bit_mask;
    mmex_pkg::ffz_res_t    ffz_res;

    mmex_ffz u_ffz
    (
        .word (word_rdata_reg),
        .res  (ffz_res)
    );

    assign value_ext = EXT_W'(value);
    assign in_range  = value_ext < EXT_W'(NUM_VALUES);
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign scan_last = scan_reg == WORD_AW'(WORDS - 1);
    assign found_idx = RES_W'({scan_reg, ffz_res.pos});
    assign bit_mask  = mmex_pkg::word_t'(1) << val_reg[mmex_pkg::WORD_SHIFT-1:0];

    assign in_stall         = state_reg != S_IDLE;
    assign out_valid        = out_valid_reg;
    assign smallest_missing = out_data_reg;

    // read addresses
    assign cnt_raddr = value_ext[CNT_AW-1:0];

    always_comb
    begin
        if (state_reg == S_SCAN)
        begin
            word_raddr = scan_last ? scan_reg : scan_reg + WORD_AW'(1);
        end
        else if (command == mmex_pkg::CMD_QUERY)
        begin
            word_raddr = '0;
        end
        else
        begin
            word_raddr = WORD_AW'(value_ext >> mmex_pkg::WORD_SHIFT);
        end
    end

    // write side: clearing sweep or read-modify-write
    always_comb
    begin
        cnt_we     = 1'b0;
        word_we    = 1'b0;
        cnt_waddr  = val_reg[CNT_AW-1:0];
        word_waddr = WORD_AW'(val_reg >> mmex_pkg::WORD_SHIFT);
        cnt_wdata  = cnt_rdata_reg;
        word_wdata = word_rdata_reg;
        if (state_reg == S_CLEAR)
        begin
            cnt_we     = 1'b1;
            word_we    = 1'b1;
            cnt_waddr  = clr_reg;
            word_waddr = WORD_AW'(clr_reg >> mmex_pkg::WORD_SHIFT);
            cnt_wdata  = '0;
            word_wdata = '0;
        end
        else if (state_reg == S_UPDATE)
        begin
            cnt_we  = 1'b1;
            word_we = 1'b1;
            if (cmd_reg == mmex_pkg::CMD_ADD)
            begin
                if (cnt_rdata_reg != COUNT_MAX)
                begin
                    cnt_wdata = cnt_rdata_reg + COUNT_BITS'(1);
                end
                word_wdata = word_rdata_reg | bit_mask;
            end
            else if (cnt_rdata_reg != '0)
            begin
                cnt_wdata = cnt_rdata_reg - COUNT_BITS'(1);
                if (cnt_rdata_reg == COUNT_BITS'(1))
                begin
                    word_wdata = word_rdata_reg & ~bit_mask;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata_reg <= count_mem[cnt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (word_we)
        begin
            word_mem[word_waddr] <= word_wdata;
        end
        word_rdata_reg <= word_mem[word_raddr];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cmd_next       = cmd_reg;
        val_next       = val_reg;
        scan_next      = scan_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + CNT_AW'(1);
                if (clr_reg == CNT_AW'(NUM_VALUES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = command;
                    val_next = value_ext;
                    if (command == mmex_pkg::CMD_QUERY)
                    begin
                        scan_next  = '0;
                        state_next = S_SCAN;
                    end
                    else if (in_range && (command == mmex_pkg::CMD_ADD
                                          || command == mmex_pkg::CMD_REMOVE))
                    begin
                        state_next = S_UPDATE;
                    end
                end
            end
            S_UPDATE:
            begin
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (ffz_res.found)
                begin
                    res_next   = (found_idx >= RES_W'(NUM_VALUES)) ? RES_W'(NUM_VALUES)
                                                                     : found_idx;
                    state_next = S_OUT;
                end
                else if (scan_last)
                begin
                    res_next   = RES_W'(NUM_VALUES);
                    state_next = S_OUT;
                end
                else
                begin
                    scan_next = scan_reg + WORD_AW'(1);
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg[mmex_pkg::RESULT_W-1:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        val_reg      <= val_next;
        scan_reg     <= scan_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

endmodule

/* hw/rtl/mmex_checker.sv */
// Port-level checker for multiset_mex_tracker_unit, attached by bind.
// Depends on mmex_pkg.
module mmex_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input mmex_pkg::cmd_t    command,
    input logic              out_valid,
    input logic              out_stall,
    input mmex_pkg::result_t smallest_missing
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(smallest_missing))
        else $error("stalled result changed");

    // a query request keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command == mmex_pkg::CMD_QUERY |=> in_stall)
        else $error("query request did not occupy the block");

    // a result appears only after busy cycles
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a busy cycle");

    // after a reset cycle: clearing, nothing delivered
    assert property (@(posedge clk)
        !rst_n |=> in_stall && !out_valid)
        else $error("block not stalled and empty after reset");

endmodule

bind multiset_mex_tracker_unit mmex_checker u_mmex_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .command          (command),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .smallest_missing (smallest_missing)
);

/* tb/multiset_mex_tracker_unit_test.sv */
// Self-checking testbench for multiset_mex_tracker_unit: directed, count depth, dense fill,
// interval sweep, back-pressure and random request streams, checked against an in-bench count
// tracker. Depends on mmex_pkg and the multiset_mex_tracker_unit RTL.
module multiset_mex_tracker_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_VALUES   = 1024;
    localparam int COUNT_BITS   = 16;
    localparam int DRAIN_CYCLES = 2 * (NUM_VALUES / mmex_pkg::WORD_BITS) + 16;
    localparam int FILL_VALUES  = 128;
    localparam int EXP_DEPTH    = 4096;
    localparam mmex_pkg::cmd_t CMD_UNUSED = 2'd3;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    mmex_pkg::cmd_t    command   = mmex_pkg::CMD_ADD;
    mmex_pkg::value_t  value     = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    mmex_pkg::result_t smallest_missing;

    logic [COUNT_BITS-1:0] value_tally [NUM_VALUES];
    bit                    value_present [NUM_VALUES];
    mmex_pkg::result_t     expected_mem [EXP_DEPTH];
    int                    exp_wr = 0;
    int                    exp_rd = 0;

    int fail_count  = 0;
    bit src_jitter  = 1'b0;
    bit sink_jitter = 1'b0;
    int long_hold   = 0;
    bit hold_done   = 1'b0;

    multiset_mex_tracker_unit
    #(
        .NUM_VALUES (NUM_VALUES),
        .COUNT_BITS (COUNT_BITS)
    )
    u_top
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .value            (value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .smallest_missing (smallest_missing)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic mmex_pkg::result_t lowest_absent();
        for (int i = 0; i < NUM_VALUES; i++)
        begin
            if (!value_present[i])
                return mmex_pkg::result_t'(i);
        end
        return mmex_pkg::result_t'(NUM_VALUES);
    endfunction

    function automatic void track_request(mmex_pkg::cmd_t cmd, mmex_pkg::value_t val);
        case (cmd)
            mmex_pkg::CMD_QUERY:
            begin
                expected_mem[exp_wr % EXP_DEPTH] = lowest_absent();
                exp_wr++;
            end
            mmex_pkg::CMD_ADD:
            begin
                if (value_tally[val] != '1)
                    value_tally[val]++;
                value_present[val] = 1'b1;
            end
            mmex_pkg::CMD_REMOVE:
            begin
                if (value_tally[val] != '0)
                begin
                    value_tally[val]--;
                    if (value_tally[val] == '0)
                        value_present[val] = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic send_request(mmex_pkg::cmd_t cmd, mmex_pkg::value_t val);
        command  <= cmd;
        value    <= val;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        track_request(cmd, val);
    endtask

    task automatic idle_sender(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic maybe_pause();
        if (src_jitter && $urandom_range(0, 3) == 0)
            idle_sender($urandom_range(1, 11));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (exp_rd != exp_wr)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_random_request();
        int               roll;
        mmex_pkg::cmd_t   cmd;
        mmex_pkg::value_t val;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            cmd = mmex_pkg::CMD_ADD;
        else if (roll < 78)
            cmd = mmex_pkg::CMD_REMOVE;
        else if (roll < 95)
            cmd = mmex_pkg::CMD_QUERY;
        else
            cmd = CMD_UNUSED;
        if ($urandom_range(0, 9) < 7)
            val = mmex_pkg::value_t'($urandom_range(0, 63));
        else
            val = mmex_pkg::value_t'($urandom_range(0, NUM_VALUES - 1));
        maybe_pause();
        send_request(cmd, val);
    endtask

    task automatic test_directed_cases();
        send_request(mmex_pkg::CMD_QUERY, '0);
        send_request(mmex_pkg::CMD_REMOVE, '0);
        send_request(mmex_pkg::CMD_QUERY, '1);
        send_request(mmex_pkg::CMD_ADD, '0);
        send_request(mmex_pkg::CMD_QUERY, '0);
        send_request(mmex_pkg::CMD_ADD, '0);
        send_request(mmex_pkg::CMD_REMOVE, '0);
        send_request(mmex_pkg::CMD_QUERY, '0);
        send_request(mmex_pkg::CMD_REMOVE, '0);
        send_request(mmex_pkg::CMD_QUERY, '0);
        send_request(mmex_pkg::CMD_ADD, '1);
        send_request(CMD_UNUSED, '0);
        send_request(mmex_pkg::CMD_QUERY, '0);
        send_request(mmex_pkg::CMD_ADD, '0);
        send_request(mmex_pkg::CMD_ADD, mmex_pkg::value_t'(1));
        send_request(mmex_pkg::CMD_QUERY, '0);
        send_request(CMD_UNUSED, mmex_pkg::value_t'(1));
        send_request(mmex_pkg::CMD_REMOVE, mmex_pkg::value_t'(1));
        send_request(CMD_UNUSED, '1);
        send_request(mmex_pkg::CMD_QUERY, '0);
        send_request(mmex_pkg::CMD_REMOVE, '0);
        send_request(mmex_pkg::CMD_QUERY, '0);
        drain_results();
    endtask

    task automatic test_count_depth();
        src_jitter  = 1'b0;
        sink_jitter = 1'b0;
        for (int k = 0; k < 24; k++)
            send_request(mmex_pkg::CMD_ADD, '0);
        send_request(mmex_pkg::CMD_QUERY, '0);
        for (int k = 0; k < 22; k++)
            send_request(mmex_pkg::CMD_REMOVE, '0);
        send_request(mmex_pkg::CMD_QUERY, '0);
        send_request(mmex_pkg::CMD_REMOVE, '0);
        send_request(mmex_pkg::CMD_QUERY, '0);
        send_request(mmex_pkg::CMD_REMOVE, '0);
        send_request(mmex_pkg::CMD_QUERY, '0);
        drain_results();
    endtask

    task automatic test_dense_fill();
        mmex_pkg::value_t val;
        src_jitter  = 1'b1;
        sink_jitter = 1'b1;
        for (int v = 0; v < FILL_VALUES; v++)
        begin
            maybe_pause();
            send_request(mmex_pkg::CMD_ADD, mmex_pkg::value_t'(v));
            if (v % 32 == 31)
                send_request(mmex_pkg::CMD_QUERY, '0);
        end
        repeat (12)
        begin
            val = mmex_pkg::value_t'($urandom_range(0, FILL_VALUES - 1));
            send_request(mmex_pkg::CMD_REMOVE, val);
            send_request(mmex_pkg::CMD_QUERY, '0);
            send_request(mmex_pkg::CMD_ADD, val);
            send_request(mmex_pkg::CMD_QUERY, '0);
        end
        for (int v = FILL_VALUES - 1; v >= 0; v--)
        begin
            maybe_pause();
            send_request(mmex_pkg::CMD_REMOVE, mmex_pkg::value_t'(v));
            if (v % 32 == 0 || v >= FILL_VALUES - 3)
                send_request(mmex_pkg::CMD_QUERY, '0);
        end
        drain_results();
    endtask

    task automatic test_interval_sweep(int rounds);
        mmex_pkg::value_t open_vals [$];
        mmex_pkg::value_t val;
        int               base;
        int               span;
        int               pick;
        src_jitter  = 1'b1;
        sink_jitter = 1'b1;
        repeat (rounds)
        begin
            base = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 40);
            span = $urandom_range(1, 12);
            for (int k = 0; k < span; k++)
            begin
                val = mmex_pkg::value_t'(base + k);
                maybe_pause();
                send_request(mmex_pkg::CMD_ADD, val);
                open_vals = {open_vals, val};
                if ($urandom_range(0, 2) == 0)
                    send_request(mmex_pkg::CMD_QUERY, val);
            end
            while (open_vals.size() > 0)
            begin
                pick = $urandom_range(0, open_vals.size() - 1);
                val  = open_vals[pick];
                open_vals.delete(pick);
                maybe_pause();
                send_request(mmex_pkg::CMD_REMOVE, val);
                if ($urandom_range(0, 2) == 0)
                    send_request(mmex_pkg::CMD_QUERY, '0);
                if ($urandom_range(0, 9) == 0)
                    send_random_request();
            end
            send_request(mmex_pkg::CMD_QUERY, '0);
        end
        drain_results();
    endtask

    task automatic test_output_hold();
        src_jitter  = 1'b0;
        sink_jitter = 1'b0;
        long_hold   = 300;
        repeat (24)
        begin
            send_request(mmex_pkg::CMD_QUERY, '0);
            send_request(mmex_pkg::CMD_ADD, mmex_pkg::value_t'($urandom_range(0, 15)));
        end
        drain_results();
    endtask

    task automatic test_random_mix(int count);
        for (int k = 0; k < count; k++)
        begin
            if (k % 50 == 0)
            begin
                src_jitter  = ($urandom_range(0, 3) != 0);
                sink_jitter = ($urandom_range(0, 3) != 0);
            end
            send_random_request();
        end
        drain_results();
    endtask

    task automatic test_quiet_tail(int count);
        src_jitter  = 1'b0;
        sink_jitter = 1'b0;
        repeat (count) send_random_request();
        drain_results();
    endtask

    always
    begin : result_throttle
        int span;
        @(posedge clk);
        if (long_hold != 0 && !hold_done)
        begin
            hold_done = 1'b1;
            out_stall <= 1'b1;
            repeat (long_hold) @(posedge clk);
            out_stall <= 1'b0;
        end
        else if (sink_jitter && $urandom_range(0, 3) == 0)
        begin
            span = $urandom_range(1, 11);
            out_stall <= 1'b1;
            repeat (span) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (exp_rd == exp_wr)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: smallest_missing=%0d at %0t",
                             smallest_missing, $realtime);
            end
            else
            begin
                if (smallest_missing !== expected_mem[exp_rd % EXP_DEPTH])
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: smallest_missing expected %0d actual %0d at %0t",
                                 expected_mem[exp_rd % EXP_DEPTH], smallest_missing,
                                 $realtime);
                end
                exp_rd++;
            end
        end
    end

    initial
    begin : run_tests
        foreach (value_tally[i])
        begin
            value_tally[i]   = '0;
            value_present[i] = 1'b0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_count_depth();
        test_dense_fill();
        test_interval_sweep(12);
        test_output_hold();
        test_random_mix(180);
        test_quiet_tail(100);
        if (fail_count == 0 && exp_rd == exp_wr)
            $display("** multiset_mex_tracker_unit: PASSED **");
        else
            $display("** multiset_mex_tracker_unit: FAILED **");
        $finish;
    end

    initial
    begin : watchdog
        #1_000_000;
        $display("** multiset_mex_tracker_unit: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/mmex_pkg.sv
hw/rtl/mmex_ffz.sv
hw/rtl/multiset_mex_tracker_unit.sv
hw/rtl/mmex_checker.sv
tb/multiset_mex_tracker_unit_test.sv
